// File: sv/damped_spring_bond_force_assert.svh
// ----------------------------------------------------------------------------
// Damped spring bond force - assertion macros
// Shorthand for the concurrent checks on the top-level ports.
// ----------------------------------------------------------------------------
`ifndef DAMPED_SPRING_BOND_FORCE_ASSERT_SVH
`define DAMPED_SPRING_BOND_FORCE_ASSERT_SVH

// Check a property on every clock edge outside of reset
`define DSBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included
`define DSBF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/dsbf_pkg.sv
// ----------------------------------------------------------------------------
// Damped spring bond force - shared package
// Word types, register codes and the sideband record that travels along
// the pipeline with each bond.
// ----------------------------------------------------------------------------
package dsbf_pkg;

  // Q16.16 data word and 31-bit unsigned register word
  localparam int unsigned DW   = 32;
  localparam int unsigned CW   = 31;
  localparam int unsigned FRAC = 16;

  // Register levels from an accepted word to its result strobe
  localparam int unsigned PIPE_DEPTH = 107;

  // Largest unsigned register value
  localparam logic [CW-1:0] UMAX = {CW{1'b1}};

  // Box length after reset: 1.0 in Q16.16
  localparam logic [CW-1:0] BOX_RESET = CW'(65536);

  typedef logic [DW-1:0]          word_t;
  typedef logic [CW-1:0]          ureg_t;
  typedef logic [2:0][DW-1:0]     vec3_t;
  typedef logic [1:0][CW-1:0]     pair_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_STIFF0   = 3'd0,
    REG_STIFF1   = 3'd1,
    REG_DAMP0    = 3'd2,
    REG_DAMP1    = 3'd3,
    REG_BOX_X    = 3'd4,
    REG_BOX_Y    = 3'd5,
    REG_BOX_Z    = 3'd6,
    REG_PERIODIC = 3'd7
  } cfg_reg_t;

  // Periodic box settings for the minimum-image stage
  typedef struct packed {
    logic [2:0][CW-1:0] len;
    logic [2:0]         periodic;
  } box_cfg_t;

  // Per-bond data that rides along unchanged until the last stages
  typedef struct packed {
    vec3_t dv;
    logic  kind;
    ureg_t rest;
    ureg_t m1;
    ureg_t m2;
  } side_t;

endpackage

// File: sv/dsbf_wrap.sv
// ----------------------------------------------------------------------------
// Damped spring bond force - minimum image
// Pipelined remainder of each position difference by its box length, one
// quotient bit per stage, then folds the remainder into (-L/2, L/2] on each periodic axis.
// ----------------------------------------------------------------------------
module dsbf_wrap (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  dsbf_pkg::vec3_t    in_dr,
  input  dsbf_pkg::side_t    in_side,
  input  dsbf_pkg::box_cfg_t box_cfg,
  output logic               out_valid,
  output dsbf_pkg::vec3_t    out_dr,
  output dsbf_pkg::side_t    out_side
);
  import dsbf_pkg::*;

  localparam int unsigned STEPS = DW;

  logic               vld_r  [0:STEPS];
  side_t              side_r [0:STEPS];
  vec3_t              d_r    [0:STEPS];
  vec3_t              mag_r  [0:STEPS];
  logic [2:0][CW-1:0] rem_r  [0:STEPS];
  logic [2:0]         en_r   [0:STEPS];
  logic [2:0][CW-1:0] rem_nxt [0:STEPS-1];

  vec3_t      mag_in;
  logic [2:0] en_in;
  vec3_t      res_nxt;
  logic       out_valid_r;
  vec3_t      out_dr_r;
  side_t      out_side_r;

  // Take magnitudes and decide which axes wrap
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag_in[a] = in_dr[a][DW-1] ? (~in_dr[a] + word_t'(1)) : in_dr[a];
      en_in[a]  = box_cfg.periodic[a] && (box_cfg.len[a] != '0);
    end
  end

  // Shift in one dividend bit per stage, subtract the box length if it fits
  always_comb begin
    logic [DW-1:0] sh;
    for (int s = 0; s < STEPS; s++) begin
      for (int a = 0; a < 3; a++) begin
        sh = {rem_r[s][a], mag_r[s][a][DW-1-s]};
        if (sh >= {1'b0, box_cfg.len[a]}) begin
          rem_nxt[s][a] = CW'(sh - {1'b0, box_cfg.len[a]});
        end else begin
          rem_nxt[s][a] = sh[CW-1:0];
        end
      end
    end
  end

  // Fold the remainder to the nearest image
  always_comb begin
    logic [CW-1:0] r;
    logic [DW:0]   rs;
    for (int a = 0; a < 3; a++) begin
      if (d_r[STEPS][a][DW-1] && (rem_r[STEPS][a] != '0)) begin
        r = box_cfg.len[a] - rem_r[STEPS][a];
      end else begin
        r = rem_r[STEPS][a];
      end
      rs = {2'b00, r};
      if ({r, 1'b0} > {1'b0, box_cfg.len[a]}) begin
        rs = rs - {2'b00, box_cfg.len[a]};
      end
      res_nxt[a] = en_r[STEPS][a] ? rs[DW-1:0] : d_r[STEPS][a];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= STEPS; s++) begin
        vld_r[s] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int s = 0; s < STEPS; s++) begin
        vld_r[s+1] <= vld_r[s];
      end
      out_valid_r <= vld_r[STEPS];
    end
  end

  // Advance data
  always_ff @(posedge clk) begin
    d_r[0]    <= in_dr;
    mag_r[0]  <= mag_in;
    rem_r[0]  <= '0;
    en_r[0]   <= en_in;
    side_r[0] <= in_side;
    for (int s = 0; s < STEPS; s++) begin
      d_r[s+1]    <= d_r[s];
      mag_r[s+1]  <= mag_r[s];
      rem_r[s+1]  <= rem_nxt[s];
      en_r[s+1]   <= en_r[s];
      side_r[s+1] <= side_r[s];
    end
    out_dr_r   <= res_nxt;
    out_side_r <= side_r[STEPS];
  end

  assign out_valid = out_valid_r;
  assign out_dr    = out_dr_r;
  assign out_side  = out_side_r;

endmodule

// File: sv/dsbf_norm.sv
// ----------------------------------------------------------------------------
// Damped spring bond force - bond length
// Squares and sums the wrapped difference, then takes the floor square
// root one result bit per stage.
// ----------------------------------------------------------------------------
module dsbf_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  dsbf_pkg::vec3_t in_dr,
  input  dsbf_pkg::side_t in_side,
  output logic            out_valid,
  output dsbf_pkg::word_t out_norm,
  output logic            out_zero,
  output dsbf_pkg::vec3_t out_dr,
  output dsbf_pkg::side_t out_side
);
  import dsbf_pkg::*;

  localparam int unsigned STEPS = DW;
  localparam int unsigned SQW   = 2 * DW;

  logic                 sq_vld_r;
  logic [2:0][SQW-1:0]  sq_r;
  vec3_t                sq_dr_r;
  side_t                sq_side_r;
  logic [2:0][SQW-1:0]  sq_in;
  logic [SQW-1:0]       sum_in;

  logic            vld_r  [0:STEPS];
  logic [SQW-1:0]  rad_r  [0:STEPS];
  logic [DW-1:0]   root_r [0:STEPS];
  logic [DW+1:0]   srem_r [0:STEPS];
  logic            zero_r [0:STEPS];
  vec3_t           dr_r   [0:STEPS];
  side_t           side_r [0:STEPS];
  logic [DW-1:0]   root_nxt [0:STEPS-1];
  logic [DW+1:0]   srem_nxt [0:STEPS-1];

  // Square each axis
  always_comb begin
    logic [DW-1:0] m;
    for (int a = 0; a < 3; a++) begin
      m = in_dr[a][DW-1] ? (~in_dr[a] + word_t'(1)) : in_dr[a];
      sq_in[a] = SQW'(m) * SQW'(m);
    end
  end

  // Sum the squares
  assign sum_in = sq_r[0] + sq_r[1] + sq_r[2];

  // Bring down two radicand bits per stage and try the next root bit
  always_comb begin
    logic [DW+3:0] sh;
    logic [DW+3:0] trial;
    for (int s = 0; s < STEPS; s++) begin
      sh    = {srem_r[s], rad_r[s][SQW-1-2*s -: 2]};
      trial = {2'b00, root_r[s], 2'b01};
      if (sh >= trial) begin
        srem_nxt[s] = (DW+2)'(sh - trial);
        root_nxt[s] = {root_r[s][DW-2:0], 1'b1};
      end else begin
        srem_nxt[s] = sh[DW+1:0];
        root_nxt[s] = {root_r[s][DW-2:0], 1'b0};
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      for (int s = 0; s <= STEPS; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      sq_vld_r <= in_valid;
      vld_r[0] <= sq_vld_r;
      for (int s = 0; s < STEPS; s++) begin
        vld_r[s+1] <= vld_r[s];
      end
    end
  end

  // Advance data
  always_ff @(posedge clk) begin
    sq_r      <= sq_in;
    sq_dr_r   <= in_dr;
    sq_side_r <= in_side;
    rad_r[0]  <= sum_in;
    root_r[0] <= '0;
    srem_r[0] <= '0;
    zero_r[0] <= (sum_in == '0);
    dr_r[0]   <= sq_dr_r;
    side_r[0] <= sq_side_r;
    for (int s = 0; s < STEPS; s++) begin
      rad_r[s+1]  <= rad_r[s];
      root_r[s+1] <= root_nxt[s];
      srem_r[s+1] <= srem_nxt[s];
      zero_r[s+1] <= zero_r[s];
      dr_r[s+1]   <= dr_r[s];
      side_r[s+1] <= side_r[s];
    end
  end

  assign out_valid = vld_r[STEPS];
  assign out_norm  = root_r[STEPS];
  assign out_zero  = zero_r[STEPS];
  assign out_dr    = dr_r[STEPS];
  assign out_side  = side_r[STEPS];

endmodule

// File: sv/dsbf_spring.sv
// ----------------------------------------------------------------------------
// Damped spring bond force - spring term
// Forms the clamped spring magnitude k*|len - rest|, scales it by each
// axis component and divides by the bond length, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dsbf_spring (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  dsbf_pkg::word_t in_norm,
  input  logic            in_zero,
  input  dsbf_pkg::vec3_t in_dr,
  input  dsbf_pkg::side_t in_side,
  input  dsbf_pkg::pair_t stiffness,
  output logic            out_valid,
  output dsbf_pkg::vec3_t out_spring,
  output logic            out_zero,
  output logic            out_sat,
  output dsbf_pkg::side_t out_side
);
  import dsbf_pkg::*;

  localparam int unsigned PW    = DW + CW;
  localparam int unsigned STEPS = CW;

  // Extension product stage
  logic          ep_vld_r;
  logic [PW-1:0] ep_prod_r;
  logic          ep_pos_r;
  logic          ep_nz_r;
  word_t         ep_norm_r;
  logic          ep_zero_r;
  vec3_t         ep_dr_r;
  side_t         ep_side_r;
  logic [DW:0]   ext_in;
  logic [DW-1:0] ext_mag;

  // Clamped magnitude stage
  logic          sm_vld_r;
  ureg_t         sm_r;
  logic          sm_sat_r;
  logic          sm_pos_r;
  logic          sm_nz_r;
  word_t         sm_norm_r;
  logic          sm_zero_r;
  vec3_t         sm_dr_r;
  side_t         sm_side_r;
  ureg_t         sm_nxt;
  logic          sm_sat_nxt;

  // Division stages
  logic                 vld_r    [0:STEPS];
  logic [2:0][PW-1:0]   num_r    [0:STEPS];
  logic [2:0][DW-1:0]   rem_r    [0:STEPS];
  logic [2:0][CW-1:0]   q_r      [0:STEPS];
  word_t                norm_r   [0:STEPS];
  logic                 zero_r   [0:STEPS];
  logic                 sat_r    [0:STEPS];
  logic                 pos_r    [0:STEPS];
  logic                 nz_r     [0:STEPS];
  logic [2:0]           drpos_r  [0:STEPS];
  logic [2:0]           drnz_r   [0:STEPS];
  side_t                side_r   [0:STEPS];
  logic [2:0][DW-1:0]   rem_nxt  [0:STEPS-1];
  logic [2:0][CW-1:0]   q_nxt    [0:STEPS-1];
  logic [2:0][PW-1:0]   num_in;
  logic [2:0]           drpos_in;
  logic [2:0]           drnz_in;

  logic  out_valid_r;
  vec3_t out_spring_r;
  logic  out_zero_r;
  logic  out_sat_r;
  side_t out_side_r;
  vec3_t spring_nxt;

  // Signed extension of the bond past its rest length
  always_comb begin
    ext_in  = {1'b0, in_norm} - {2'b00, in_side.rest};
    ext_mag = ext_in[DW] ? DW'(~ext_in + (DW+1)'(1)) : ext_in[DW-1:0];
  end

  // Scale down and clamp the spring magnitude
  always_comb begin
    logic [PW-FRAC-1:0] full;
    full       = ep_prod_r[PW-1:FRAC];
    sm_nxt     = '0;
    sm_sat_nxt = 1'b0;
    if (!ep_zero_r) begin
      if (full > (PW-FRAC)'(UMAX)) begin
        sm_nxt     = UMAX;
        sm_sat_nxt = 1'b1;
      end else begin
        sm_nxt = full[CW-1:0];
      end
    end
  end

  // Multiply the magnitude by each axis component
  always_comb begin
    logic [DW-1:0] m;
    for (int a = 0; a < 3; a++) begin
      m = sm_dr_r[a][DW-1] ? (~sm_dr_r[a] + word_t'(1)) : sm_dr_r[a];
      num_in[a]   = PW'(sm_r) * PW'(m);
      drpos_in[a] = !sm_dr_r[a][DW-1] && (sm_dr_r[a] != '0);
      drnz_in[a]  = (sm_dr_r[a] != '0);
    end
  end

  // Restoring division by the bond length, one quotient bit per stage
  always_comb begin
    logic [DW:0] sh;
    for (int s = 0; s < STEPS; s++) begin
      for (int a = 0; a < 3; a++) begin
        sh = {rem_r[s][a], num_r[s][a][CW-1-s]};
        if (sh >= {1'b0, norm_r[s]}) begin
          rem_nxt[s][a] = DW'(sh - {1'b0, norm_r[s]});
          q_nxt[s][a]   = {q_r[s][a][CW-2:0], 1'b1};
        end else begin
          rem_nxt[s][a] = sh[DW-1:0];
          q_nxt[s][a]   = {q_r[s][a][CW-2:0], 1'b0};
        end
      end
    end
  end

  // Apply the sign; drop the term for a zero bond, zero extension or axis
  always_comb begin
    logic [DW-1:0] qw;
    for (int a = 0; a < 3; a++) begin
      qw = {1'b0, q_r[STEPS][a]};
      if (!zero_r[STEPS] && nz_r[STEPS] && drnz_r[STEPS][a]) begin
        spring_nxt[a] = (pos_r[STEPS] == drpos_r[STEPS][a]) ? (~qw + word_t'(1)) : qw;
      end else begin
        spring_nxt[a] = '0;
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ep_vld_r <= 1'b0;
      sm_vld_r <= 1'b0;
      for (int s = 0; s <= STEPS; s++) begin
        vld_r[s] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      ep_vld_r <= in_valid;
      sm_vld_r <= ep_vld_r;
      vld_r[0] <= sm_vld_r;
      for (int s = 0; s < STEPS; s++) begin
        vld_r[s+1] <= vld_r[s];
      end
      out_valid_r <= vld_r[STEPS];
    end
  end

  // Advance data
  always_ff @(posedge clk) begin
    ep_prod_r <= PW'(stiffness[in_side.kind]) * PW'(ext_mag);
    ep_pos_r  <= !ext_in[DW] && (ext_in != '0);
    ep_nz_r   <= (ext_in != '0);
    ep_norm_r <= in_norm;
    ep_zero_r <= in_zero;
    ep_dr_r   <= in_dr;
    ep_side_r <= in_side;

    sm_r      <= sm_nxt;
    sm_sat_r  <= sm_sat_nxt;
    sm_pos_r  <= ep_pos_r;
    sm_nz_r   <= ep_nz_r;
    sm_norm_r <= ep_norm_r;
    sm_zero_r <= ep_zero_r;
    sm_dr_r   <= ep_dr_r;
    sm_side_r <= ep_side_r;

    num_r[0] <= num_in;
    for (int a = 0; a < 3; a++) begin
      rem_r[0][a] <= num_in[a][PW-1:CW];
    end
    q_r[0]     <= '0;
    norm_r[0]  <= sm_norm_r;
    zero_r[0]  <= sm_zero_r;
    sat_r[0]   <= sm_sat_r;
    pos_r[0]   <= sm_pos_r;
    nz_r[0]    <= sm_nz_r;
    drpos_r[0] <= drpos_in;
    drnz_r[0]  <= drnz_in;
    side_r[0]  <= sm_side_r;
    for (int s = 0; s < STEPS; s++) begin
      num_r[s+1]   <= num_r[s];
      rem_r[s+1]   <= rem_nxt[s];
      q_r[s+1]     <= q_nxt[s];
      norm_r[s+1]  <= norm_r[s];
      zero_r[s+1]  <= zero_r[s];
      sat_r[s+1]   <= sat_r[s];
      pos_r[s+1]   <= pos_r[s];
      nz_r[s+1]    <= nz_r[s];
      drpos_r[s+1] <= drpos_r[s];
      drnz_r[s+1]  <= drnz_r[s];
      side_r[s+1]  <= side_r[s];
    end

    out_spring_r <= spring_nxt;
    out_zero_r   <= zero_r[STEPS];
    out_sat_r    <= sat_r[STEPS];
    out_side_r   <= side_r[STEPS];
  end

  assign out_valid  = out_valid_r;
  assign out_spring = out_spring_r;
  assign out_zero   = out_zero_r;
  assign out_sat    = out_sat_r;
  assign out_side   = out_side_r;

endmodule

// File: sv/dsbf_force.sv
// ----------------------------------------------------------------------------
// Damped spring bond force - damping and accelerations
// Subtracts the damping term from the spring term, clamps the force and
// scales it by both inverse masses.
// ----------------------------------------------------------------------------
module dsbf_force (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  dsbf_pkg::vec3_t in_spring,
  input  logic            in_zero,
  input  logic            in_sat,
  input  dsbf_pkg::side_t in_side,
  input  dsbf_pkg::pair_t damping,
  output logic            out_valid,
  output dsbf_pkg::vec3_t out_accel_first,
  output dsbf_pkg::vec3_t out_accel_second,
  output logic            out_zero,
  output logic            out_sat
);
  import dsbf_pkg::*;

  localparam int unsigned PW = DW + CW;
  localparam int unsigned MW = PW - FRAC;
  localparam int unsigned FW = MW + 2;

  // Damping product stage
  logic               dp_vld_r;
  logic [2:0][PW-1:0] dp_prod_r;
  logic [2:0]         dp_neg_r;
  vec3_t              dp_spring_r;
  ureg_t              dp_m1_r;
  ureg_t              dp_m2_r;
  logic               dp_zero_r;
  logic               dp_sat_r;
  logic [2:0][PW-1:0] dp_prod_in;

  // Force stage
  logic       fc_vld_r;
  vec3_t      fc_r;
  ureg_t      fc_m1_r;
  ureg_t      fc_m2_r;
  logic       fc_zero_r;
  logic       fc_sat_r;
  vec3_t      fc_nxt;
  logic       fc_sat_nxt;

  // Acceleration product stage
  logic               ap_vld_r;
  logic [2:0][PW-1:0] ap_p1_r;
  logic [2:0][PW-1:0] ap_p2_r;
  logic [2:0]         ap_neg_r;
  logic               ap_zero_r;
  logic               ap_sat_r;
  logic [2:0][PW-1:0] ap_p1_in;
  logic [2:0][PW-1:0] ap_p2_in;

  logic  out_valid_r;
  vec3_t out_a1_r;
  vec3_t out_a2_r;
  logic  out_zero_r;
  logic  out_sat_r;
  vec3_t a1_nxt;
  vec3_t a2_nxt;
  logic  acc_sat_nxt;

  // Clamp a signed magnitude to the 32-bit range; top bit flags a clamp
  function automatic logic [DW:0] clamp_mag(input logic [MW-1:0] m, input logic neg);
    logic [DW-1:0] v;
    logic          s;
    s = 1'b0;
    if (neg) begin
      if (m > MW'({1'b1, {(DW-1){1'b0}}})) begin
        v = {1'b1, {(DW-1){1'b0}}};
        s = 1'b1;
      end else begin
        v = ~m[DW-1:0] + word_t'(1);
      end
    end else begin
      if (m > MW'({1'b0, {(DW-1){1'b1}}})) begin
        v = {1'b0, {(DW-1){1'b1}}};
        s = 1'b1;
      end else begin
        v = m[DW-1:0];
      end
    end
    return {s, v};
  endfunction

  // Multiply each velocity magnitude by the damping coefficient
  always_comb begin
    logic [DW-1:0] m;
    for (int a = 0; a < 3; a++) begin
      m = in_side.dv[a][DW-1] ? (~in_side.dv[a] + word_t'(1)) : in_side.dv[a];
      dp_prod_in[a] = PW'(m) * PW'(damping[in_side.kind]);
    end
  end

  // Subtract damping from spring and clamp the force
  always_comb begin
    logic [FW-1:0] sp;
    logic [FW-1:0] dm;
    logic [FW-1:0] f;
    fc_sat_nxt = dp_sat_r;
    for (int a = 0; a < 3; a++) begin
      sp = {{(FW-DW){dp_spring_r[a][DW-1]}}, dp_spring_r[a]};
      dm = {2'b00, dp_prod_r[a][PW-1:FRAC]};
      f  = dp_neg_r[a] ? (sp + dm) : (sp - dm);
      if (!f[FW-1] && (f[FW-2:DW-1] != '0)) begin
        fc_nxt[a]  = {1'b0, {(DW-1){1'b1}}};
        fc_sat_nxt = 1'b1;
      end else if (f[FW-1] && !(&f[FW-2:DW-1])) begin
        fc_nxt[a]  = {1'b1, {(DW-1){1'b0}}};
        fc_sat_nxt = 1'b1;
      end else begin
        fc_nxt[a] = f[DW-1:0];
      end
    end
  end

  // Multiply each force magnitude by both inverse masses
  always_comb begin
    logic [DW-1:0] m;
    for (int a = 0; a < 3; a++) begin
      m = fc_r[a][DW-1] ? (~fc_r[a] + word_t'(1)) : fc_r[a];
      ap_p1_in[a] = PW'(m) * PW'(fc_m1_r);
      ap_p2_in[a] = PW'(m) * PW'(fc_m2_r);
    end
  end

  // Scale, sign and clamp the accelerations: first atom takes -F
  always_comb begin
    logic [DW:0] r1;
    logic [DW:0] r2;
    acc_sat_nxt = ap_sat_r;
    for (int a = 0; a < 3; a++) begin
      r1 = clamp_mag(ap_p1_r[a][PW-1:FRAC], !ap_neg_r[a]);
      r2 = clamp_mag(ap_p2_r[a][PW-1:FRAC], ap_neg_r[a]);
      a1_nxt[a]   = r1[DW-1:0];
      a2_nxt[a]   = r2[DW-1:0];
      acc_sat_nxt = acc_sat_nxt | r1[DW] | r2[DW];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_vld_r    <= 1'b0;
      fc_vld_r    <= 1'b0;
      ap_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dp_vld_r    <= in_valid;
      fc_vld_r    <= dp_vld_r;
      ap_vld_r    <= fc_vld_r;
      out_valid_r <= ap_vld_r;
    end
  end

  // Advance data; flags show only with a result
  always_ff @(posedge clk) begin
    dp_prod_r   <= dp_prod_in;
    for (int a = 0; a < 3; a++) begin
      dp_neg_r[a] <= in_side.dv[a][DW-1];
    end
    dp_spring_r <= in_spring;
    dp_m1_r     <= in_side.m1;
    dp_m2_r     <= in_side.m2;
    dp_zero_r   <= in_zero;
    dp_sat_r    <= in_sat;

    fc_r      <= fc_nxt;
    fc_m1_r   <= dp_m1_r;
    fc_m2_r   <= dp_m2_r;
    fc_zero_r <= dp_zero_r;
    fc_sat_r  <= fc_sat_nxt;

    ap_p1_r <= ap_p1_in;
    ap_p2_r <= ap_p2_in;
    for (int a = 0; a < 3; a++) begin
      ap_neg_r[a] <= fc_r[a][DW-1];
    end
    ap_zero_r <= fc_zero_r;
    ap_sat_r  <= fc_sat_r;

    out_a1_r   <= a1_nxt;
    out_a2_r   <= a2_nxt;
    out_zero_r <= ap_zero_r & ap_vld_r;
    out_sat_r  <= acc_sat_nxt & ap_vld_r;
  end

  assign out_valid        = out_valid_r;
  assign out_accel_first  = out_a1_r;
  assign out_accel_second = out_a2_r;
  assign out_zero         = out_zero_r;
  assign out_sat          = out_sat_r;

endmodule

// File: sv/damped_spring_bond_force.sv
// Throughput: one bond per clock; busy stays low, start may be held high.
// Depth is set by the bit-per-stage remainder, square root and divider.
// Reset (rst_n low, synchronous) empties the pipeline, clears the
// coefficients and periodic mask and sets each box length to 1.0.
// ----------------------------------------------------------------------------
// Damped spring bond force - top level
// Register file and the four pipeline sections: minimum image, bond
// length, spring term, damping and accelerations.
// ----------------------------------------------------------------------------
module damped_spring_bond_force (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_delta_pos_x,
  input  logic [31:0] in_delta_pos_y,
  input  logic [31:0] in_delta_pos_z,
  input  logic [31:0] in_delta_vel_x,
  input  logic [31:0] in_delta_vel_y,
  input  logic [31:0] in_delta_vel_z,
  input  logic        in_bond_kind,
  input  logic [30:0] in_rest_length,
  input  logic [30:0] in_inv_mass_first,
  input  logic [30:0] in_inv_mass_second,
  output logic        out_valid,
  output logic [31:0] out_accel_first_x,
  output logic [31:0] out_accel_first_y,
  output logic [31:0] out_accel_first_z,
  output logic [31:0] out_accel_second_x,
  output logic [31:0] out_accel_second_y,
  output logic [31:0] out_accel_second_z,
  output logic        out_zero_length,
  output logic        out_saturated,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);
  import dsbf_pkg::*;

  pair_t      stiff_r;
  pair_t      damp_r;
  box_cfg_t   box_r;

  logic       accept;
  vec3_t      dr_in;
  side_t      side_in;

  logic       wr_valid;
  vec3_t      wr_dr;
  side_t      wr_side;
  logic       nm_valid;
  word_t      nm_norm;
  logic       nm_zero;
  vec3_t      nm_dr;
  side_t      nm_side;
  logic       sp_valid;
  vec3_t      sp_spring;
  logic       sp_zero;
  logic       sp_sat;
  side_t      sp_side;
  vec3_t      acc1;
  vec3_t      acc2;

  // Busy never rises, so a word is taken whenever start is high
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r       <= '0;
      damp_r        <= '0;
      box_r.len     <= {BOX_RESET, BOX_RESET, BOX_RESET};
      box_r.periodic <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STIFF0:   stiff_r[0]     <= cfg_wdata;
        REG_STIFF1:   stiff_r[1]     <= cfg_wdata;
        REG_DAMP0:    damp_r[0]      <= cfg_wdata;
        REG_DAMP1:    damp_r[1]      <= cfg_wdata;
        REG_BOX_X:    box_r.len[0]   <= cfg_wdata;
        REG_BOX_Y:    box_r.len[1]   <= cfg_wdata;
        REG_BOX_Z:    box_r.len[2]   <= cfg_wdata;
        REG_PERIODIC: box_r.periodic <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Gather the input word
  assign dr_in        = {in_delta_pos_z, in_delta_pos_y, in_delta_pos_x};
  assign side_in.dv   = {in_delta_vel_z, in_delta_vel_y, in_delta_vel_x};
  assign side_in.kind = in_bond_kind;
  assign side_in.rest = in_rest_length;
  assign side_in.m1   = in_inv_mass_first;
  assign side_in.m2   = in_inv_mass_second;

  dsbf_wrap u_wrap (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_dr     (dr_in),
    .in_side   (side_in),
    .box_cfg   (box_r),
    .out_valid (wr_valid),
    .out_dr    (wr_dr),
    .out_side  (wr_side)
  );

  dsbf_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (wr_valid),
    .in_dr     (wr_dr),
    .in_side   (wr_side),
    .out_valid (nm_valid),
    .out_norm  (nm_norm),
    .out_zero  (nm_zero),
    .out_dr    (nm_dr),
    .out_side  (nm_side)
  );

  dsbf_spring u_spring (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (nm_valid),
    .in_norm    (nm_norm),
    .in_zero    (nm_zero),
    .in_dr      (nm_dr),
    .in_side    (nm_side),
    .stiffness  (stiff_r),
    .out_valid  (sp_valid),
    .out_spring (sp_spring),
    .out_zero   (sp_zero),
    .out_sat    (sp_sat),
    .out_side   (sp_side)
  );

  dsbf_force u_force (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (sp_valid),
    .in_spring        (sp_spring),
    .in_zero          (sp_zero),
    .in_sat           (sp_sat),
    .in_side          (sp_side),
    .damping          (damp_r),
    .out_valid        (out_valid),
    .out_accel_first  (acc1),
    .out_accel_second (acc2),
    .out_zero         (out_zero_length),
    .out_sat          (out_saturated)
  );

  // Spread the result word onto its ports
  assign out_accel_first_x  = acc1[0];
  assign out_accel_first_y  = acc1[1];
  assign out_accel_first_z  = acc1[2];
  assign out_accel_second_x = acc2[0];
  assign out_accel_second_y = acc2[1];
  assign out_accel_second_z = acc2[2];

endmodule

// File: sv/dsbf_checker.sv
// ----------------------------------------------------------------------------
// Damped spring bond force - port checker
// Watches the start and result strobes for the fixed pipeline timing, and the flags.
// ----------------------------------------------------------------------------
`include "damped_spring_bond_force_assert.svh"

module dsbf_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_zero_length,
  input logic out_saturated
);
  import dsbf_pkg::*;

  // Each accepted word returns exactly one result after the pipe depth
  `DSBF_ASSERT(a_result_follows, (start && !busy) |-> ##PIPE_DEPTH out_valid, "result missing")
  `DSBF_ASSERT(a_no_spurious, !(start && !busy) |-> ##PIPE_DEPTH !out_valid, "result invented")
  // Flags stay quiet between results
  `DSBF_ASSERT(a_flags_quiet, !out_valid |-> (!out_zero_length && !out_saturated), "stray flag")
  // Reset empties the pipeline
  `DSBF_ASSERT_ALWAYS(a_reset_flush, !rst_n |=> !out_valid, "result after reset")

endmodule

bind damped_spring_bond_force dsbf_checker u_dsbf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_zero_length (out_zero_length),
  .out_saturated   (out_saturated)
);
